// File: rtl/vdl_pkg.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting package
// Shared types, register indexes, constants and the 16.16 multiply helper.
// ----------------------------------------------------------------------------
package vdl_pkg;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 216;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [20:0] FULL_INTENSITY = 21'(31 * 65536);
   localparam logic [4:0]  AMBIENT_FULL   = 5'd31;
   localparam int          GAIN_SCALE     = 31;
   localparam int          FALLOFF_SHIFT_A = 15;
   localparam int          FALLOFF_SHIFT_B = 14;
   localparam logic        MODE_SHADE     = 1'b1;

   typedef enum logic [1:0] {
      REG_SECTOR_AMBIENT,
      REG_AMBIENT_FRACTION,
      REG_SCALED_AMBIENT,
      REG_LIGHT_COUNT
   } reg_index_type;

   typedef enum logic {
      KIND_LOAD,
      KIND_SHADE
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [2:0]    index;
      logic [31:0]   vx;
      logic [31:0]   vy;
      logic [31:0]   vz;
      logic [31:0]   aux;
      logic          last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [16:0] gain;
      logic [31:0] dir_z;
      logic [31:0] dir_y;
      logic [31:0] dir_x;
   } light_type;

   typedef struct packed {
      logic [4:0]  sector_ambient;
      logic [16:0] ambient_fraction;
      logic [20:0] scaled_ambient;
      logic [3:0]  light_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_CLAMP,
      ST_DONE
   } back_state_type;

   // Product of two 16.16 values, shifted right by 16 and kept to 32 bits.
   function automatic logic [31:0] fx_mul(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[47:16];
   endfunction

endpackage

// File: rtl/vdl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/vdl_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vdl_queue
   import vdl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/vdl_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions, sorts light loads from shade items and
// prepares the relative normal and depth falloff of each vertex.
// ----------------------------------------------------------------------------
module vdl_front
   import vdl_pkg::*;
#(
   parameter int MAX_LIGHTS = 8
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   input  queue_status_type      status,
   output logic                  push,
   output item_type              push_item
);

   logic        mode;
   logic [2:0]  light_index;
   logic [31:0] vec_x, vec_y, vec_z;
   logic [31:0] normal_x, normal_y, normal_z;
   logic [16:0] brightness;
   logic [31:0] depth;
   logic        index_ok;

   assign mode        = req_tuser[0];
   assign light_index = req_tuser[3:1];
   assign vec_x       = req_tdata[31:0];
   assign vec_y       = req_tdata[63:32];
   assign vec_z       = req_tdata[95:64];
   assign normal_x    = req_tdata[127:96];
   assign normal_y    = req_tdata[159:128];
   assign normal_z    = req_tdata[191:160];
   assign brightness  = req_tdata[208:192];

   assign req_tready = !status.full;
   assign index_ok   = (32'(light_index) < 32'(MAX_LIGHTS));
   assign depth      = vec_z[31] ? '0 : vec_z;

   always_comb begin
      push_item.index = light_index;
      push_item.last  = req_tlast;
      if (mode == MODE_SHADE) begin
         push_item.kind = KIND_SHADE;
         push_item.vx   = normal_x - vec_x;
         push_item.vy   = normal_y - vec_y;
         push_item.vz   = normal_z - vec_z;
         push_item.aux  = (depth >> FALLOFF_SHIFT_A) + (depth >> FALLOFF_SHIFT_B);
      end else begin
         push_item.kind = KIND_LOAD;
         push_item.vx   = vec_x;
         push_item.vy   = vec_y;
         push_item.vz   = vec_z;
         push_item.aux  = 32'(brightness);
      end
   end

   assign push = req_tvalid && req_tready && ((mode == MODE_SHADE) || index_ok);

endmodule

// File: rtl/vdl_back.sv
// ----------------------------------------------------------------------------
// Back end
// Writes the light table and shades vertices, one light term per cycle
// through a four-stage multiply pipeline, then scales, clamps and delivers.
// ----------------------------------------------------------------------------
module vdl_back
   import vdl_pkg::*;
#(
   parameter int MAX_LIGHTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  item_type              head_item,
   input  queue_status_type      status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int CW = $clog2(MAX_LIGHTS + 1);

   back_state_type state_ff, state_in;

   logic          ram_we;
   logic          issue;
   logic          last_issue;
   logic          out_load;
   logic          pipe_busy;
   logic [CW-1:0] count;
   light_type     wdata;
   light_type     rdata;

   logic [AW-1:0] idx_ff;
   logic [31:0]   diff_x_ff, diff_y_ff, diff_z_ff;
   logic [31:0]   falloff_ff;
   logic          last_ff;
   logic          rd_vld_ff, vld1_ff, vld2_ff, vld3_ff;
   logic [31:0]   mx_ff, my_ff, mz_ff;
   logic [16:0]   gain1_ff;
   logic [31:0]   dot_ff;
   logic [21:0]   src_ff;
   logic [31:0]   term_ff;
   logic [31:0]   acc_ff;
   logic [31:0]   scaled_ff;
   logic [20:0]   res_ff, res_in;
   logic          rsp_tvalid_ff;
   logic [20:0]   rsp_int_ff;
   logic          rsp_last_ff;

   always_comb begin
      if (32'(cfg.light_count) < 32'(MAX_LIGHTS)) begin
         count = CW'(cfg.light_count);
      end else begin
         count = CW'(MAX_LIGHTS);
      end
   end

   assign pipe_busy  = rd_vld_ff || vld1_ff || vld2_ff || vld3_ff;
   assign last_issue = (CW'(idx_ff) + CW'(1) == count);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!status.empty && (head_item.kind == KIND_SHADE)) begin
               if (cfg.sector_ambient >= AMBIENT_FULL) begin
                  state_in = ST_DONE;
               end else if (count == '0) begin
                  state_in = ST_SCALE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      issue    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE:  pop      = !status.empty;
         ST_RUN:   issue    = 1'b1;
         ST_DONE:  out_load = !rsp_tvalid_ff || rsp_tready;
         default: begin
            pop      = 1'b0;
            issue    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   assign ram_we      = pop && (head_item.kind == KIND_LOAD);
   assign wdata.gain  = head_item.aux[16:0];
   assign wdata.dir_x = head_item.vx;
   assign wdata.dir_y = head_item.vy;
   assign wdata.dir_z = head_item.vz;

   vdl_ram #(
      .WIDTH ($bits(light_type)),
      .DEPTH (MAX_LIGHTS)
   ) u_light_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(head_item.index)),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         vld1_ff       <= 1'b0;
         vld2_ff       <= 1'b0;
         vld3_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         vld1_ff   <= rd_vld_ff;
         vld2_ff   <= vld1_ff;
         vld3_ff   <= vld2_ff;
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      logic        [31:0] amb;
      logic        [31:0] top;
      logic        [31:0] diff;
      logic signed [32:0] v;
      amb  = {11'b0, cfg.sector_ambient, 16'b0};
      top  = ($signed(scaled_ff) > $signed(amb)) ? scaled_ff : amb;
      diff = top - falloff_ff;
      v    = $signed({diff[31], diff});
      if (v < $signed({12'b0, cfg.scaled_ambient})) begin
         v = $signed({12'b0, cfg.scaled_ambient});
      end
      if (v > $signed({12'b0, FULL_INTENSITY})) begin
         v = $signed({12'b0, FULL_INTENSITY});
      end
      res_in = v[20:0];
   end

   always_ff @(posedge clock) begin
      if (pop && (head_item.kind == KIND_SHADE)) begin
         diff_x_ff  <= head_item.vx;
         diff_y_ff  <= head_item.vy;
         diff_z_ff  <= head_item.vz;
         falloff_ff <= head_item.aux;
         last_ff    <= head_item.last;
         acc_ff     <= '0;
         idx_ff     <= '0;
         res_ff     <= FULL_INTENSITY;
      end else begin
         if (issue) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (vld3_ff) begin
            acc_ff <= acc_ff + term_ff;
         end
         if (state_ff == ST_CLAMP) begin
            res_ff <= res_in;
         end
      end
      mx_ff     <= fx_mul(diff_x_ff, rdata.dir_x);
      my_ff     <= fx_mul(diff_y_ff, rdata.dir_y);
      mz_ff     <= fx_mul(diff_z_ff, rdata.dir_z);
      gain1_ff  <= rdata.gain;
      dot_ff    <= mx_ff + my_ff + mz_ff;
      src_ff    <= 22'(gain1_ff) * 22'(GAIN_SCALE);
      term_ff   <= (!dot_ff[31] && (dot_ff != '0)) ? fx_mul(dot_ff, 32'(src_ff)) : '0;
      scaled_ff <= fx_mul(acc_ff, 32'(cfg.ambient_fraction));
      if (out_load) begin
         rsp_int_ff  <= res_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_int_ff);
   assign rsp_tlast  = rsp_last_ff;

   a_pipe_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_SCALE) |-> !pipe_busy)
      else $error("light pipeline busy outside a shading pass");

   a_int_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_int_ff <= FULL_INTENSITY))
      else $error("intensity above full scale");

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (CW'(idx_ff) < count))
      else $error("light index beyond light count");

endmodule

// File: rtl/vertex_diffuse_lighting_unit.sv
// ----------------------------------------------------------------------------
// Vertex diffuse lighting unit
// Fixed-point Lambert shading of view-space vertices with a directional
// light table, an ambient floor and a depth falloff.
// ----------------------------------------------------------------------------
// A light load transaction is taken from the queue and written to the light
// table by the back end. A shade transaction with n lights in use
// (light_count, capped at MAX_LIGHTS) is taken from the queue, runs a light
// loop of n reads, one table entry per cycle through the single read port of
// the light table, drains its four-stage multiply pipeline, and is then
// scaled, clamped and handed over. With no lights in use the loop is skipped,
// and with a fully lit sector it goes straight to the hand-over. The hand-over
// waits while the result register still holds an earlier transaction that the
// receiver has not taken. A two-entry queue lets the request side run ahead of
// the shading loop, and the result register holds a finished transaction while
// the next one is worked on.
// ----------------------------------------------------------------------------
module vertex_diffuse_lighting_unit
   import vdl_pkg::*;
#(
   parameter int MAX_LIGHTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vec_x, vec_y, vec_z, normal_x, normal_y, normal_z, brightness, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode, light_index
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // intensity, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type          cfg_ff;
   reg_index_type    reg_index;
   logic             csr_wr;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head_item;
   queue_status_type status;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sector_ambient   <= '0;
         cfg_ff.ambient_fraction <= 17'(65536);
         cfg_ff.scaled_ambient   <= '0;
         cfg_ff.light_count      <= '0;
      end else if (csr_wr) begin
         case (reg_index)
            REG_SECTOR_AMBIENT:   cfg_ff.sector_ambient   <= csr_pwdata[4:0];
            REG_AMBIENT_FRACTION: cfg_ff.ambient_fraction <= csr_pwdata[16:0];
            REG_SCALED_AMBIENT:   cfg_ff.scaled_ambient   <= csr_pwdata[20:0];
            REG_LIGHT_COUNT:      cfg_ff.light_count      <= csr_pwdata[3:0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SECTOR_AMBIENT:   csr_prdata = CSR_DATA_W'(cfg_ff.sector_ambient);
         REG_AMBIENT_FRACTION: csr_prdata = CSR_DATA_W'(cfg_ff.ambient_fraction);
         REG_SCALED_AMBIENT:   csr_prdata = CSR_DATA_W'(cfg_ff.scaled_ambient);
         REG_LIGHT_COUNT:      csr_prdata = CSR_DATA_W'(cfg_ff.light_count);
         default:              csr_prdata = '0;
      endcase
   end

   vdl_front #(
      .MAX_LIGHTS (MAX_LIGHTS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .status     (status),
      .push       (push),
      .push_item  (push_item)
   );

   vdl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (status)
   );

   vdl_back #(
      .MAX_LIGHTS (MAX_LIGHTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_item  (head_item),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
